// ===== hw/rtl/utf8_stream_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// utf8_stream_decoder assertion macros
// Shared concurrent assertion forms for the decoder, with reset disable.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== hw/rtl/u8d_pkg.sv =====
// ---------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int CP_W          = 21;
    localparam int DEFAULT_DEPTH = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // One queue entry holds every result that a single byte causes.
    // A pair is always a replacement followed by the result in cp/bad.
    typedef struct packed {
        logic            pair;
        logic [CP_W-1:0] cp;
        logic            bad;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u8d_front.sv =====
// ---------------------------------------------------------------------------
// u8d_front
// Accepts bytes, keeps the sequence state and classifies each byte into
// the results it causes, which are pushed as one queue entry.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            q_full,
    output logic                 push,
    output u8d_pkg::entry_t      push_entry
);
    import u8d_pkg::*;

    typedef struct packed {
        logic            has;
        logic [CP_W-1:0] cp;
        logic            bad;
        logic [1:0]      cnt;
        logic [CP_W-1:0] part;
    } lead_t;

    logic [1:0]      pending_count_reg, pending_count_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            has_result;
    logic            accept;

    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t r;
        r = '0;
        if (b[7] == 1'b0) begin
            r.has = 1'b1;
            r.cp  = {{(CP_W-8){1'b0}}, b};
        end
        else if (b[7:5] == 3'b110) begin
            r.cnt  = 2'd1;
            r.part = {{(CP_W-5){1'b0}}, b[4:0]};
        end
        else if (b[7:4] == 4'b1110) begin
            r.cnt  = 2'd2;
            r.part = {{(CP_W-4){1'b0}}, b[3:0]};
        end
        else if (b[7:3] == 5'b11110) begin
            r.cnt  = 2'd3;
            r.part = {{(CP_W-3){1'b0}}, b[2:0]};
        end
        else begin
            r.has = 1'b1;
            r.cp  = REPLACEMENT_CP;
            r.bad = 1'b1;
        end
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && has_result;

    always_comb
    begin
        lead_t           ld;
        logic [CP_W-1:0] acc;
        ld                 = decode_lead(in_byte);
        acc                = {partial_reg[CP_W-7:0], in_byte[5:0]};
        pending_count_next = pending_count_reg;
        partial_next       = partial_reg;
        has_result         = 1'b0;
        push_entry         = '0;
        if (pending_count_reg != 2'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                pending_count_next = pending_count_reg - 2'd1;
                if (pending_count_reg == 2'd1) begin
                    has_result    = 1'b1;
                    push_entry.cp = acc;
                    partial_next  = '0;
                end
                else begin
                    partial_next = acc;
                end
            end
            else begin
                // Interrupted sequence: replacement first, then the byte
                // is taken again as a lead byte.
                has_result         = 1'b1;
                pending_count_next = ld.cnt;
                partial_next       = ld.part;
                if (ld.has) begin
                    push_entry.pair = 1'b1;
                    push_entry.cp   = ld.cp;
                    push_entry.bad  = ld.bad;
                end
                else begin
                    push_entry.cp  = REPLACEMENT_CP;
                    push_entry.bad = 1'b1;
                end
            end
        end
        else begin
            has_result         = ld.has;
            pending_count_next = ld.cnt;
            partial_next       = ld.part;
            push_entry.cp      = ld.cp;
            push_entry.bad     = ld.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_count_reg <= 2'd0;
            partial_reg       <= '0;
        end
        else if (accept) begin
            pending_count_reg <= pending_count_next;
            partial_reg       <= partial_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_queue.sv =====
// ---------------------------------------------------------------------------
// u8d_queue
// Small register queue of decoded entries between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_queue #(
    parameter int DEPTH = u8d_pkg::DEFAULT_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8d_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output u8d_pkg::entry_t      q_entry
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_back.sv =====
// ---------------------------------------------------------------------------
// u8d_back
// Pops queue entries and presents their results one per output transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire u8d_pkg::entry_t           q_entry,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [u8d_pkg::CP_W-1:0]       code_point,
    output logic                           malformed,
    output logic                           last_of_run
);
    import u8d_pkg::*;

    logic            out_valid_reg, out_valid_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            bad_reg, bad_next;
    logic            last_reg, last_next;
    logic            second_reg, second_next;
    logic [CP_W-1:0] second_cp_reg, second_cp_next;
    logic            second_bad_reg, second_bad_next;
    logic            can_load;

    assign can_load    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign code_point  = cp_reg;
    assign malformed   = bad_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        cp_next         = cp_reg;
        bad_next        = bad_reg;
        last_next       = last_reg;
        second_next     = second_reg;
        second_cp_next  = second_cp_reg;
        second_bad_next = second_bad_reg;
        pop             = 1'b0;
        if (can_load) begin
            if (second_reg) begin
                out_valid_next = 1'b1;
                cp_next        = second_cp_reg;
                bad_next       = second_bad_reg;
                last_next      = 1'b1;
                second_next    = 1'b0;
            end
            else if (q_valid) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (q_entry.pair) begin
                    cp_next         = REPLACEMENT_CP;
                    bad_next        = 1'b1;
                    last_next       = 1'b0;
                    second_next     = 1'b1;
                    second_cp_next  = q_entry.cp;
                    second_bad_next = q_entry.bad;
                end
                else begin
                    cp_next   = q_entry.cp;
                    bad_next  = q_entry.bad;
                    last_next = 1'b1;
                end
            end
            else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg         <= cp_next;
        bad_reg        <= bad_next;
        last_reg       <= last_next;
        second_cp_reg  <= second_cp_next;
        second_bad_reg <= second_bad_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// utf8_stream_decoder: one byte per cycle in while the queue is not full, set by the
// combinational front decode. Each result is held in the queue, then in the output
// register; a byte that causes two results holds the output register for two transfers.
// Reset (rst_n low, asynchronous) clears the sequence state, queue and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8d_pkg::DEFAULT_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [u8d_pkg::CP_W-1:0]    code_point,
    output logic                        malformed,
    output logic                        last_of_run
);
    import u8d_pkg::*;

    // The front holds the pending continuation count and the partial code
    // point. Every byte it accepts is reduced to one queue entry that lists
    // the results the byte causes, or to nothing when the byte only opens or
    // extends a sequence. Because the entry is complete at push time, the
    // front never waits on the output side except when the queue is full.
    entry_t push_entry;
    logic   push;
    logic   q_full;

    // The queue lets the front keep taking bytes while the back side is
    // stalled or busy presenting the second result of an interrupted
    // sequence.
    entry_t q_entry;
    logic   q_valid;
    logic   pop;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // The back owns the output register. A pair entry is presented as the
    // replacement first, then the lead-byte result with last_of_run set.
    u8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .malformed   (malformed),
        .last_of_run (last_of_run)
    );

    // The first result of a pair is always a malformed replacement.
    `U8D_ASSERT_SAME(a_first_is_repl, clk, rst_n, out_valid && !last_of_run,
        malformed && (code_point == REPLACEMENT_CP))

    // The second result of a pair follows in the very next cycle.
    `U8D_ASSERT_NEXT(a_second_follows, clk, rst_n, out_valid && out_ready && !last_of_run,
        out_valid && last_of_run)

    // With the queue empty and the last result of a run taken, output goes idle.
    `U8D_ASSERT_NEXT(a_drain_idle, clk, rst_n,
        out_valid && out_ready && last_of_run && !q_valid, !out_valid)

endmodule

`default_nettype wire

// ===== tb/utf8_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder testbench
// Feeds the decoder a byte stream over the valid/ready input channel and
// checks every output transfer against an in-bench decoder model. A short
// stimulus table covers the field extremes and the error cases. A random
// stream follows that is mostly well-formed sequences, mixed with broken
// sequences and raw noise. Both channels stall at random.
// ---------------------------------------------------------------------------

module utf8_stream_decoder_tb;

    import u8d_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int STIM_ROWS     = 28;

    // One decoded code point as the output channel presents it.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            last;
    } code_point_t;

    // One row of the stimulus table. Where typed is set, the row causes
    // exactly one result and that result is written out in the row itself.
    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        code_point_t want;
    } stim_row_t;

    localparam code_point_t NO_RESULT = '0;

    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        // Extremes of the ASCII range decode to themselves.
        '{8'h00, 1'b1, '{21'h000000, 1'b0, 1'b1}},
        '{8'h7F, 1'b1, '{21'h00007F, 1'b0, 1'b1}},
        // Stray continuation bytes with nothing pending.
        '{8'h80, 1'b1, '{REPLACEMENT_CP, 1'b1, 1'b1}},
        '{8'hBF, 1'b1, '{REPLACEMENT_CP, 1'b1, 1'b1}},
        // Invalid lead bytes at both ends of the 11111xxx range.
        '{8'hF8, 1'b1, '{REPLACEMENT_CP, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, '{REPLACEMENT_CP, 1'b1, 1'b1}},
        // Two-byte sequence.
        '{8'hC2, 1'b0, NO_RESULT},
        '{8'hA9, 1'b0, NO_RESULT},
        // Three-byte sequence.
        '{8'hE2, 1'b0, NO_RESULT},
        '{8'h82, 1'b0, NO_RESULT},
        '{8'hAC, 1'b0, NO_RESULT},
        // Four-byte sequence.
        '{8'hF0, 1'b0, NO_RESULT},
        '{8'h9F, 1'b0, NO_RESULT},
        '{8'h98, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        // Largest value the accumulator can hold.
        '{8'hF7, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        // A sequence cut short by an ASCII byte gives a pair of results.
        '{8'hC3, 1'b0, NO_RESULT},
        '{8'h41, 1'b0, NO_RESULT},
        // A sequence cut short by a new lead byte, which then completes.
        '{8'hE0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hC1, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        // A sequence cut short by an invalid lead gives two replacements.
        '{8'hF0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        // Back to idle with a plain byte.
        '{8'h55, 1'b0, NO_RESULT}
    };

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [7:0]      in_byte;
    logic            out_valid;
    logic            out_ready;
    logic [CP_W-1:0] code_point;
    logic            malformed;
    logic            last_of_run;

    // Decoder model state: continuation bytes still owed and the bits so far.
    logic [1:0]      seq_left;
    logic [CP_W-1:0] seq_acc;

    // Code points the decoder still owes us, oldest first.
    code_point_t     owed_code_points [$];

    int              mismatch_count;
    int              cycle_count;
    int              bytes_sent;
    int              burst_left;
    int              rx_left;

    utf8_stream_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .malformed   (malformed),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog. The limit is far above the slowest legal run, so reaching it
    // means a transfer never happened.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("utf8_stream_decoder regression: fail");
            $finish;
        end
    end

    // Handle a byte with nothing pending: either a result right away or the
    // opening of a new sequence, in which case zero is returned.
    function automatic int decode_lead(input logic [7:0] b, output code_point_t r);
        r = '0;
        casez (b)
            8'b0???????:
            begin
                r.cp = CP_W'(b);
                return 1;
            end
            8'b110?????:
            begin
                seq_acc  = CP_W'(b[4:0]);
                seq_left = 2'd1;
                return 0;
            end
            8'b1110????:
            begin
                seq_acc  = CP_W'(b[3:0]);
                seq_left = 2'd2;
                return 0;
            end
            8'b11110???:
            begin
                seq_acc  = CP_W'(b[2:0]);
                seq_left = 2'd3;
                return 0;
            end
            default:
            begin
                // A stray continuation byte or an 11111xxx lead.
                r.cp  = REPLACEMENT_CP;
                r.bad = 1'b1;
                return 1;
            end
        endcase
    endfunction

    // Advance the decoder model by one accepted byte and queue what it owes.
    // A typed table row queues its written-out result in place of the model's.
    task automatic decode_and_queue(input logic [7:0] b, input logic typed,
                                    input code_point_t want);
        code_point_t res [2];
        int          n;
        res[0] = '0;
        res[1] = '0;
        n      = 0;
        if (seq_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                // Continuation: shift in six more bits, masked to the width.
                seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0)
                begin
                    res[0].cp = seq_acc;
                    seq_acc   = '0;
                    n         = 1;
                end
            end
            else
            begin
                // The pending sequence is abandoned and the byte starts over.
                res[0].cp  = REPLACEMENT_CP;
                res[0].bad = 1'b1;
                seq_left   = 2'd0;
                seq_acc    = '0;
                n          = 1 + decode_lead(b, res[1]);
            end
        end
        else
        begin
            n = decode_lead(b, res[0]);
        end
        if (n > 0)
        begin
            res[n-1].last = 1'b1;
        end
        if (typed)
        begin
            owed_code_points.push_back(want);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                owed_code_points.push_back(res[i]);
            end
        end
    endtask

    // Hold the input channel idle for a number of cycles. Valid is lowered on
    // the falling edge so the last accepted byte is not taken a second time.
    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Present one byte and wait for its transfer. The sender works in bursts;
    // between bursts it leaves a random gap, sometimes none at all.
    task automatic send_byte(input logic [7:0] b, input logic typed, input code_point_t want);
        if (burst_left == 0)
        begin
            idle_sender($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        bytes_sent = bytes_sent + 1;
        decode_and_queue(b, typed, want);
    endtask

    // Lead byte for a sequence of the given total length, random payload bits.
    function automatic logic [7:0] make_lead(input int len);
        case (len)
            1:       return {1'b0, 7'($urandom)};
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] make_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    // Any byte that is not a continuation byte, so it cuts a sequence short.
    function automatic logic [7:0] make_breaker();
        case ($urandom_range(0, 2))
            0:       return make_lead(1);
            1:       return make_lead($urandom_range(2, 4));
            default: return {5'b11111, 3'($urandom)};
        endcase
    endfunction

    // Receiver: ready follows a pattern of its own. Mostly short random runs
    // of ready or stall, with an occasional long stretch of steady ready.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left > 0)
            begin
                rx_left <= rx_left - 1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b1;
                rx_left   <= $urandom_range(20, 60);
            end
            else
            begin
                out_ready <= 1'($urandom_range(0, 1));
                rx_left   <= $urandom_range(0, 5);
            end
        end
    end

    // Output checker: every transfer must match the oldest owed code point.
    always @(posedge clk)
    begin
        code_point_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_code_points.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got cp=%06h bad=%0b last=%0b",
                         $time, code_point, malformed, last_of_run);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                head = owed_code_points.pop_front();
                if (code_point !== head.cp)
                begin
                    $display("%0t: code_point mismatch, expected %06h, got %06h",
                             $time, head.cp, code_point);
                    mismatch_count = mismatch_count + 1;
                end
                if (malformed !== head.bad)
                begin
                    $display("%0t: malformed mismatch, expected %0b, got %0b",
                             $time, head.bad, malformed);
                    mismatch_count = mismatch_count + 1;
                end
                if (last_of_run !== head.last)
                begin
                    $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                             $time, head.last, last_of_run);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Main sequence: reset, the stimulus table, the random stream, then drain.
    initial
    begin
        int  pick;
        int  len;
        int  conts;
        logic pressure_done;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        out_ready      = 1'b0;
        seq_left       = 2'd0;
        seq_acc        = '0;
        mismatch_count = 0;
        bytes_sent     = 0;
        burst_left     = 0;
        rx_left        = 0;
        pressure_done  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: walk the table in order.
        for (int i = 0; i < STIM_ROWS; i++)
        begin
            send_byte(STIM_TABLE[i].data, STIM_TABLE[i].typed, STIM_TABLE[i].want);
        end

        // Random part. Most of it is well-formed sequences with random payload,
        // so the multi-byte paths are exercised; the rest is broken sequences
        // and raw noise bytes, which also toggle every input bit.
        while (bytes_sent < STIM_ROWS + RANDOM_ITEMS)
        begin
            if (!pressure_done && bytes_sent >= STIM_ROWS + RANDOM_ITEMS / 2)
            begin
                // Let the decoder drain completely before going on.
                idle_sender(1);
                while (owed_code_points.size() != 0)
                begin
                    @(posedge clk);
                end
                pressure_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(1, 4);
                send_byte(make_lead(len), 1'b0, NO_RESULT);
                for (int k = 1; k < len; k++)
                begin
                    send_byte(make_cont(), 1'b0, NO_RESULT);
                end
            end
            else if (pick < 85)
            begin
                len   = $urandom_range(2, 4);
                conts = $urandom_range(0, len - 2);
                send_byte(make_lead(len), 1'b0, NO_RESULT);
                for (int k = 0; k < conts; k++)
                begin
                    send_byte(make_cont(), 1'b0, NO_RESULT);
                end
                send_byte(make_breaker(), 1'b0, NO_RESULT);
            end
            else
            begin
                send_byte(8'($urandom), 1'b0, NO_RESULT);
            end
        end

        // Drain: wait for every owed code point, then a few more cycles so a
        // spurious late transfer is still caught.
        idle_sender(1);
        while (owed_code_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("utf8_stream_decoder regression: pass");
        end
        else
        begin
            $display("utf8_stream_decoder regression: fail");
        end
        $finish;
    end

endmodule
